/* rtl/ccbe_pkg.sv */
// ccbe_pkg: shared widths, constants and lane/merge types for the checksum evidence block
// no dependencies; imported by every module under rtl
`default_nettype none
package ccbe_pkg;

	localparam int LANES     = 8;
	localparam int IDX_W     = $clog2(LANES);
	localparam int LEN_W     = 4;
	localparam int SEG_W     = 16;
	localparam int CNT_BITS  = 16;
	localparam int FLIP_BITS = CNT_BITS + 3;
	localparam int OUT_W     = 16;
	localparam int FLIP_OUT_W = 19;
	localparam int POP_W     = $clog2(LANES + 1);
	localparam int MIN_LEN   = 2;

	localparam logic [IDX_W-1:0] CB_RESET = IDX_W'(LANES - 1);
	localparam logic [LEN_W-1:0] LEN_MAX  = LEN_W'(LANES);

	typedef logic [7:0] byte_t;
	typedef byte_t [LANES-1:0] payload_t;

	typedef struct packed {
		byte_t other;
		logic  changed;
	} lane_out_t;

	typedef lane_out_t [LANES-1:0] lane_vec_t;

	typedef struct packed {
		logic             sum_hit;
		logic             cpl_hit;
		logic             xor_hit;
		logic             even;
		logic             changed;
		logic [POP_W-1:0] flips;
	} merge_t;

endpackage
`default_nettype wire

/* rtl/ccbe_lane.sv */
// ccbe_lane: one payload byte lane; masks the byte when it is the check byte or out of length
// depends on ccbe_pkg
`default_nettype none
module ccbe_lane (
	input  wire logic [ccbe_pkg::IDX_W-1:0] lane_idx,
	input  wire logic [ccbe_pkg::LEN_W-1:0] len,
	input  wire logic [ccbe_pkg::IDX_W-1:0] cb,
	input  wire ccbe_pkg::byte_t            data,
	input  wire ccbe_pkg::byte_t            prev,
	output ccbe_pkg::lane_out_t             lane_out
);
	import ccbe_pkg::*;

	logic is_other;

	always_comb begin
		is_other = (LEN_W'(lane_idx) < len) && (lane_idx != cb);
		lane_out.other   = is_other ? data : 8'h00;
		lane_out.changed = is_other && (data != prev);
	end

endmodule
`default_nettype wire

/* rtl/ccbe_merge.sv */
// ccbe_merge: combines lane results into sum, complement, xor, parity, change and flip evidence for one frame
// depends on ccbe_pkg
`default_nettype none
module ccbe_merge (
	input  wire ccbe_pkg::lane_vec_t         lanes,
	input  wire ccbe_pkg::payload_t          data,
	input  wire ccbe_pkg::payload_t          prev,
	input  wire logic [ccbe_pkg::IDX_W-1:0]  cb,
	output ccbe_pkg::merge_t                 merged
);
	import ccbe_pkg::*;

	byte_t sum;
	byte_t x;
	byte_t chk;
	byte_t pchk;
	logic  any_changed;

	always_comb begin
		sum = 8'h00;
		x = 8'h00;
		any_changed = 1'b0;
		for (int i = 0; i < LANES; i++) begin
			sum = sum + lanes[i].other;
			x = x ^ lanes[i].other;
			any_changed = any_changed | lanes[i].changed;
		end
		chk = data[cb];
		pchk = prev[cb];
		merged.sum_hit = (chk == sum);
		merged.cpl_hit = (chk == byte_t'(8'h00 - sum));
		merged.xor_hit = (chk == x);
		merged.even    = ~((^x) ^ (^chk));
		merged.changed = any_changed;
		merged.flips   = POP_W'($countones(chk ^ pchk));
	end

endmodule
`default_nettype wire

/* rtl/can_checksum_byte_evidence.sv */
// can_checksum_byte_evidence: top level; input stage, eight byte lanes, merge, saturating counters
// depends on ccbe_pkg, ccbe_lane, ccbe_merge
//
// channel  direction  handshake            payload
// in       in         in_valid/in_stall    start_of_set, data_length, payload_byte_0..7, segment_tag
// out      out        out_valid/out_stall  frame_counted and eight counter fields
// cfg      in         cfg_valid/cfg_ready  check_byte_index
//
// one frame per cycle unless out stalls; beats are registered in the input stage, then on out
// the input stage register takes a new beat while a result waits on a stalled output
// lanes, merge and counter update all sit between the input stage and the counter registers
// reset clears counters, previous-frame valid and sets check_byte_index to 7
// a stall on out backs up into in_stall only once the input stage is also full
`default_nettype none
module can_checksum_byte_evidence (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          in_valid,
	output logic                               in_stall,
	input  wire logic                          start_of_set,
	input  wire logic [3:0]                    data_length,
	input  wire logic [7:0]                    payload_byte_0,
	input  wire logic [7:0]                    payload_byte_1,
	input  wire logic [7:0]                    payload_byte_2,
	input  wire logic [7:0]                    payload_byte_3,
	input  wire logic [7:0]                    payload_byte_4,
	input  wire logic [7:0]                    payload_byte_5,
	input  wire logic [7:0]                    payload_byte_6,
	input  wire logic [7:0]                    payload_byte_7,
	input  wire logic [15:0]                   segment_tag,
	output logic                               out_valid,
	input  wire logic                          out_stall,
	output logic                               frame_counted,
	output logic [ccbe_pkg::OUT_W-1:0]         frames_counted,
	output logic [ccbe_pkg::OUT_W-1:0]         sum_matches,
	output logic [ccbe_pkg::OUT_W-1:0]         complement_matches,
	output logic [ccbe_pkg::OUT_W-1:0]         xor_matches,
	output logic [ccbe_pkg::OUT_W-1:0]         even_parity_frames,
	output logic [ccbe_pkg::OUT_W-1:0]         changed_pairs,
	output logic [ccbe_pkg::OUT_W-1:0]         check_changes,
	output logic [ccbe_pkg::FLIP_OUT_W-1:0]    changed_bits_total,
	input  wire logic                          cfg_valid,
	output logic                               cfg_ready,
	input  wire logic [ccbe_pkg::IDX_W-1:0]    check_byte_index
);
	import ccbe_pkg::*;

	localparam logic [CNT_BITS-1:0]  CNT_MAX  = {CNT_BITS{1'b1}};
	localparam logic [FLIP_BITS-1:0] FLIP_MAX = {FLIP_BITS{1'b1}};

	function automatic logic [CNT_BITS-1:0] sat_inc(input logic [CNT_BITS-1:0] c,
		input logic hit);
		sat_inc = (hit && (c != CNT_MAX)) ? c + 1'b1 : c;
	endfunction

	logic [IDX_W-1:0] cb_q;

	logic             valid_s1;
	logic             start_s1;
	logic [LEN_W-1:0] len_s1;
	payload_t         data_s1;
	logic [SEG_W-1:0] seg_s1;

	logic             out_valid_q;
	logic             counted_q;
	logic             prev_valid_q;
	logic [LEN_W-1:0] prev_len_q;
	logic [SEG_W-1:0] prev_seg_q;
	payload_t         prev_payload_q;

	logic [CNT_BITS-1:0]  frame_q, sum_q, cpl_q, xor_q, par_q, pair_q, chg_q;
	logic [FLIP_BITS-1:0] flip_q;

	logic             hold_s1;
	logic             adv_s1;
	logic             load_s1;
	logic [LEN_W-1:0] len_eff;
	logic             counted;
	logic             pair_hit;
	logic             prev_ok;
	lane_vec_t        lanes;
	merge_t           merged;

	logic [CNT_BITS-1:0]  frame_b, sum_b, cpl_b, xor_b, par_b, pair_b, chg_b;
	logic [FLIP_BITS-1:0] flip_b;
	logic [FLIP_BITS:0]   flip_sum;
	logic [CNT_BITS-1:0]  frame_n, sum_n, cpl_n, xor_n, par_n, pair_n, chg_n;
	logic [FLIP_BITS-1:0] flip_n;

	assign cfg_ready = 1'b1;

	assign hold_s1  = out_valid_q && out_stall;
	assign adv_s1   = valid_s1 && !hold_s1;
	assign in_stall = valid_s1 && hold_s1;
	assign load_s1  = in_valid && !in_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cb_q <= CB_RESET;
		end else if (cfg_valid && cfg_ready) begin
			cb_q <= check_byte_index;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (load_s1) begin
			valid_s1 <= 1'b1;
		end else if (adv_s1) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load_s1) begin
			start_s1 <= start_of_set;
			len_s1   <= data_length;
			seg_s1   <= segment_tag;
			data_s1  <= {payload_byte_7, payload_byte_6, payload_byte_5, payload_byte_4,
				payload_byte_3, payload_byte_2, payload_byte_1, payload_byte_0};
		end
	end

	assign len_eff = (len_s1 > LEN_MAX) ? LEN_MAX : len_s1;
	assign counted = (len_eff >= LEN_W'(MIN_LEN)) && (LEN_W'(cb_q) < len_eff);

	for (genvar i = 0; i < LANES; i++) begin : g_lane
		ccbe_lane u_lane (
			.lane_idx (IDX_W'(i)),
			.len      (len_eff),
			.cb       (cb_q),
			.data     (data_s1[i]),
			.prev     (prev_payload_q[i]),
			.lane_out (lanes[i])
		);
	end

	ccbe_merge u_merge (
		.lanes  (lanes),
		.data   (data_s1),
		.prev   (prev_payload_q),
		.cb     (cb_q),
		.merged (merged)
	);

	always_comb begin
		prev_ok  = prev_valid_q && !start_s1;
		pair_hit = counted && prev_ok && (prev_seg_q == seg_s1) && (prev_len_q == len_eff)
			&& merged.changed;
		frame_b = start_s1 ? '0 : frame_q;
		sum_b   = start_s1 ? '0 : sum_q;
		cpl_b   = start_s1 ? '0 : cpl_q;
		xor_b   = start_s1 ? '0 : xor_q;
		par_b   = start_s1 ? '0 : par_q;
		pair_b  = start_s1 ? '0 : pair_q;
		chg_b   = start_s1 ? '0 : chg_q;
		flip_b  = start_s1 ? '0 : flip_q;
		frame_n = sat_inc(frame_b, counted);
		sum_n   = sat_inc(sum_b, counted && merged.sum_hit);
		cpl_n   = sat_inc(cpl_b, counted && merged.cpl_hit);
		xor_n   = sat_inc(xor_b, counted && merged.xor_hit);
		par_n   = sat_inc(par_b, counted && merged.even);
		pair_n  = sat_inc(pair_b, pair_hit);
		chg_n   = sat_inc(chg_b, pair_hit && (merged.flips != '0));
		flip_sum = {1'b0, flip_b} + (FLIP_BITS + 1)'(merged.flips);
		if (!pair_hit) begin
			flip_n = flip_b;
		end else if (flip_sum > {1'b0, FLIP_MAX}) begin
			flip_n = FLIP_MAX;
		end else begin
			flip_n = flip_sum[FLIP_BITS-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q  <= 1'b0;
			counted_q    <= 1'b0;
			prev_valid_q <= 1'b0;
			prev_len_q   <= '0;
			prev_seg_q   <= '0;
			frame_q      <= '0;
			sum_q        <= '0;
			cpl_q        <= '0;
			xor_q        <= '0;
			par_q        <= '0;
			pair_q       <= '0;
			chg_q        <= '0;
			flip_q       <= '0;
		end else if (adv_s1) begin
			out_valid_q  <= 1'b1;
			counted_q    <= counted;
			prev_valid_q <= counted;
			if (counted) begin
				prev_len_q <= len_eff;
				prev_seg_q <= seg_s1;
			end
			frame_q <= frame_n;
			sum_q   <= sum_n;
			cpl_q   <= cpl_n;
			xor_q   <= xor_n;
			par_q   <= par_n;
			pair_q  <= pair_n;
			chg_q   <= chg_n;
			flip_q  <= flip_n;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s1 && counted) begin
			prev_payload_q <= data_s1;
		end
	end

	assign out_valid          = out_valid_q;
	assign frame_counted      = counted_q;
	assign frames_counted     = OUT_W'(frame_q);
	assign sum_matches        = OUT_W'(sum_q);
	assign complement_matches = OUT_W'(cpl_q);
	assign xor_matches        = OUT_W'(xor_q);
	assign even_parity_frames = OUT_W'(par_q);
	assign changed_pairs      = OUT_W'(pair_q);
	assign check_changes      = OUT_W'(chg_q);
	assign changed_bits_total = FLIP_OUT_W'(flip_q);

	a_adv_shows: assert property (@(posedge clk) disable iff (!arst_n)
		adv_s1 |=> out_valid_q && (counted_q == $past(counted)))
		else $error("advanced beat not presented on out");

	a_skip_keeps: assert property (@(posedge clk) disable iff (!arst_n)
		adv_s1 && !counted && !start_s1 |=> frame_q == $past(frame_q) && !prev_valid_q)
		else $error("skipped frame changed frame count or kept previous frame");

	a_pair_le_frame: assert property (@(posedge clk) disable iff (!arst_n)
		(chg_q <= pair_q) && (pair_q <= frame_q) && (sum_q <= frame_q))
		else $error("counter ordering broken");

	a_flip_ge_chg: assert property (@(posedge clk) disable iff (!arst_n)
		FLIP_BITS'(chg_q) <= flip_q)
		else $error("flipped bit total below changed check count");

endmodule
`default_nettype wire

/* bench/evidence_checker.sv */
`timescale 1ns / 100ps
// evidence_checker: watches the frame, result and register channels of the checksum evidence
// block, keeps its own copy of the counters and compares every result beat field by field
// depends on ccbe_pkg for widths and the reset byte index
module evidence_checker (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              in_valid,
	input  logic                              in_stall,
	input  logic                              start_of_set,
	input  logic [3:0]                        data_length,
	input  logic [7:0]                        payload_byte_0,
	input  logic [7:0]                        payload_byte_1,
	input  logic [7:0]                        payload_byte_2,
	input  logic [7:0]                        payload_byte_3,
	input  logic [7:0]                        payload_byte_4,
	input  logic [7:0]                        payload_byte_5,
	input  logic [7:0]                        payload_byte_6,
	input  logic [7:0]                        payload_byte_7,
	input  logic [15:0]                       segment_tag,
	input  logic                              out_valid,
	input  logic                              out_stall,
	input  logic                              frame_counted,
	input  logic [ccbe_pkg::OUT_W-1:0]        frames_counted,
	input  logic [ccbe_pkg::OUT_W-1:0]        sum_matches,
	input  logic [ccbe_pkg::OUT_W-1:0]        complement_matches,
	input  logic [ccbe_pkg::OUT_W-1:0]        xor_matches,
	input  logic [ccbe_pkg::OUT_W-1:0]        even_parity_frames,
	input  logic [ccbe_pkg::OUT_W-1:0]        changed_pairs,
	input  logic [ccbe_pkg::OUT_W-1:0]        check_changes,
	input  logic [ccbe_pkg::FLIP_OUT_W-1:0]   changed_bits_total,
	input  logic                              cfg_valid,
	input  logic                              cfg_ready,
	input  logic [ccbe_pkg::IDX_W-1:0]        check_byte_index,
	output int                                failures,
	output int                                outstanding
);
	import ccbe_pkg::*;

	localparam int unsigned COUNT_CAP   = (32'd1 << CNT_BITS) - 1;
	localparam int unsigned FLIP_CAP    = (32'd1 << FLIP_BITS) - 1;
	localparam int          PRINT_LIMIT = 64;

	typedef struct packed {
		logic                    counted;
		logic [OUT_W-1:0]        frames;
		logic [OUT_W-1:0]        sums;
		logic [OUT_W-1:0]        cpls;
		logic [OUT_W-1:0]        xors;
		logic [OUT_W-1:0]        evens;
		logic [OUT_W-1:0]        pairs;
		logic [OUT_W-1:0]        changes;
		logic [FLIP_OUT_W-1:0]   flips;
	} evidence_t;

	evidence_t         evidence_q[$];
	logic [IDX_W-1:0]  check_idx = CB_RESET;
	logic              prev_valid = 1'b0;
	int unsigned       prev_len = 0;
	logic [SEG_W-1:0]  prev_seg = '0;
	payload_t          prev_data = '0;
	int unsigned       frame_n = 0;
	int unsigned       sum_n = 0;
	int unsigned       cpl_n = 0;
	int unsigned       xor_n = 0;
	int unsigned       even_n = 0;
	int unsigned       pair_n = 0;
	int unsigned       change_n = 0;
	int unsigned       flip_n = 0;
	int                mismatches = 0;
	int                beat_no = 0;

	assign failures = mismatches;

	function automatic int unsigned sat_add(input int unsigned cur, input int unsigned by,
			input int unsigned cap);
		return (by >= cap - cur) ? cap : cur + by;
	endfunction

	task automatic clear_history();
		prev_valid = 1'b0;
		prev_len = 0;
		prev_seg = '0;
		prev_data = '0;
		frame_n = 0;
		sum_n = 0;
		cpl_n = 0;
		xor_n = 0;
		even_n = 0;
		pair_n = 0;
		change_n = 0;
		flip_n = 0;
	endtask

	task automatic report_mismatch(input string field, input logic [31:0] got,
			input logic [31:0] want);
		if (mismatches < PRINT_LIMIT)
			$display("[%0t] mismatch on %s at result beat %0d: got %0h, want %0h",
				$time, field, beat_no, got, want);
		mismatches++;
	endtask

	task automatic score_frame();
		int unsigned len;
		int unsigned flips;
		int          j;
		byte_t       chk;
		byte_t       sum;
		byte_t       x;
		logic        moved;
		payload_t    data;
		evidence_t   want;
		data = {payload_byte_7, payload_byte_6, payload_byte_5, payload_byte_4,
			payload_byte_3, payload_byte_2, payload_byte_1, payload_byte_0};
		if (start_of_set)
			clear_history();
		len = (data_length > LANES) ? LANES : data_length;
		want.counted = (len >= MIN_LEN) && (check_idx < len);
		if (!want.counted) begin
			prev_valid = 1'b0;
		end else begin
			chk = data[check_idx];
			sum = '0;
			x = '0;
			for (j = 0; j < len; j++) begin
				if (j != check_idx) begin
					sum = sum + data[j];
					x = x ^ data[j];
				end
			end
			frame_n = sat_add(frame_n, 1, COUNT_CAP);
			if (chk == sum)
				sum_n = sat_add(sum_n, 1, COUNT_CAP);
			if (chk == byte_t'(8'd0 - sum))
				cpl_n = sat_add(cpl_n, 1, COUNT_CAP);
			if (chk == x)
				xor_n = sat_add(xor_n, 1, COUNT_CAP);
			if ((($countones(x) + $countones(chk)) % 2) == 0)
				even_n = sat_add(even_n, 1, COUNT_CAP);
			if (prev_valid && prev_seg == segment_tag && prev_len == len) begin
				moved = 1'b0;
				for (j = 0; j < len; j++)
					if (j != check_idx && data[j] != prev_data[j])
						moved = 1'b1;
				if (moved) begin
					flips = $countones(chk ^ prev_data[check_idx]);
					pair_n = sat_add(pair_n, 1, COUNT_CAP);
					if (flips != 0)
						change_n = sat_add(change_n, 1, COUNT_CAP);
					flip_n = sat_add(flip_n, flips, FLIP_CAP);
				end
			end
			prev_valid = 1'b1;
			prev_len = len;
			prev_seg = segment_tag;
			prev_data = data;
		end
		want.frames = OUT_W'(frame_n);
		want.sums = OUT_W'(sum_n);
		want.cpls = OUT_W'(cpl_n);
		want.xors = OUT_W'(xor_n);
		want.evens = OUT_W'(even_n);
		want.pairs = OUT_W'(pair_n);
		want.changes = OUT_W'(change_n);
		want.flips = FLIP_OUT_W'(flip_n);
		evidence_q.push_back(want);
	endtask

	task automatic compare_beat();
		evidence_t want;
		beat_no++;
		if (evidence_q.size() == 0) begin
			report_mismatch("result beat with nothing expected", 0, 0);
		end else begin
			want = evidence_q.pop_front();
			if (frame_counted !== want.counted)
				report_mismatch("frame_counted", frame_counted, want.counted);
			if (frames_counted !== want.frames)
				report_mismatch("frames_counted", frames_counted, want.frames);
			if (sum_matches !== want.sums)
				report_mismatch("sum_matches", sum_matches, want.sums);
			if (complement_matches !== want.cpls)
				report_mismatch("complement_matches", complement_matches, want.cpls);
			if (xor_matches !== want.xors)
				report_mismatch("xor_matches", xor_matches, want.xors);
			if (even_parity_frames !== want.evens)
				report_mismatch("even_parity_frames", even_parity_frames, want.evens);
			if (changed_pairs !== want.pairs)
				report_mismatch("changed_pairs", changed_pairs, want.pairs);
			if (check_changes !== want.changes)
				report_mismatch("check_changes", check_changes, want.changes);
			if (changed_bits_total !== want.flips)
				report_mismatch("changed_bits_total", changed_bits_total, want.flips);
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			check_idx = CB_RESET;
			clear_history();
			evidence_q.delete();
			outstanding <= 0;
		end else begin
			if (cfg_valid && cfg_ready)
				check_idx = check_byte_index;
			if (out_valid && !out_stall)
				compare_beat();
			if (in_valid && !in_stall)
				score_frame();
			outstanding <= evidence_q.size();
		end
	end

endmodule

/* bench/tb.sv */
`timescale 1ns / 100ps
// tb: drives CAN frames and byte index writes into can_checksum_byte_evidence with random
// bursts and output stalls; evidence_checker predicts and compares the result beats
// depends on ccbe_pkg, can_checksum_byte_evidence and evidence_checker
module tb;
	import ccbe_pkg::*;

	localparam longint RUN_LIMIT_NS  = 64'd40_000_000;
	localparam int     RANDOM_FRAMES = 1500;
	localparam int     PHASES        = 6;
	localparam int     B2B_FRAMES    = 48;

	typedef enum {FLOW, LIGHT, HEAVY, PULSED} stall_mode_t;
	typedef enum {SCH_SUM, SCH_CPL, SCH_XOR, SCH_PARITY, SCH_RANDOM, SCH_HOLD} check_scheme_t;

	logic                   clk = 1'b0;
	logic                   arst_n;
	logic                   in_valid;
	logic                   in_stall;
	logic                   start_of_set;
	logic [3:0]             data_length;
	logic [7:0]             payload_byte_0;
	logic [7:0]             payload_byte_1;
	logic [7:0]             payload_byte_2;
	logic [7:0]             payload_byte_3;
	logic [7:0]             payload_byte_4;
	logic [7:0]             payload_byte_5;
	logic [7:0]             payload_byte_6;
	logic [7:0]             payload_byte_7;
	logic [15:0]            segment_tag;
	logic                   out_valid;
	logic                   out_stall = 1'b0;
	logic                   frame_counted;
	logic [OUT_W-1:0]       frames_counted;
	logic [OUT_W-1:0]       sum_matches;
	logic [OUT_W-1:0]       complement_matches;
	logic [OUT_W-1:0]       xor_matches;
	logic [OUT_W-1:0]       even_parity_frames;
	logic [OUT_W-1:0]       changed_pairs;
	logic [OUT_W-1:0]       check_changes;
	logic [FLIP_OUT_W-1:0]  changed_bits_total;
	logic                   cfg_valid;
	logic                   cfg_ready;
	logic [IDX_W-1:0]       check_byte_index;
	int                     failures;
	int                     outstanding;

	stall_mode_t            stall_mode = FLOW;
	int unsigned            stall_left = 0;
	int unsigned            beats_left = 0;
	int unsigned            frames_sent = 0;
	bit                     gaps_on = 1'b1;
	int unsigned            cur_cb = CB_RESET;

	can_checksum_byte_evidence u_top (
		.clk                (clk),
		.arst_n             (arst_n),
		.in_valid           (in_valid),
		.in_stall           (in_stall),
		.start_of_set       (start_of_set),
		.data_length        (data_length),
		.payload_byte_0     (payload_byte_0),
		.payload_byte_1     (payload_byte_1),
		.payload_byte_2     (payload_byte_2),
		.payload_byte_3     (payload_byte_3),
		.payload_byte_4     (payload_byte_4),
		.payload_byte_5     (payload_byte_5),
		.payload_byte_6     (payload_byte_6),
		.payload_byte_7     (payload_byte_7),
		.segment_tag        (segment_tag),
		.out_valid          (out_valid),
		.out_stall          (out_stall),
		.frame_counted      (frame_counted),
		.frames_counted     (frames_counted),
		.sum_matches        (sum_matches),
		.complement_matches (complement_matches),
		.xor_matches        (xor_matches),
		.even_parity_frames (even_parity_frames),
		.changed_pairs      (changed_pairs),
		.check_changes      (check_changes),
		.changed_bits_total (changed_bits_total),
		.cfg_valid          (cfg_valid),
		.cfg_ready          (cfg_ready),
		.check_byte_index   (check_byte_index)
	);

	evidence_checker u_chk (
		.clk                (clk),
		.arst_n             (arst_n),
		.in_valid           (in_valid),
		.in_stall           (in_stall),
		.start_of_set       (start_of_set),
		.data_length        (data_length),
		.payload_byte_0     (payload_byte_0),
		.payload_byte_1     (payload_byte_1),
		.payload_byte_2     (payload_byte_2),
		.payload_byte_3     (payload_byte_3),
		.payload_byte_4     (payload_byte_4),
		.payload_byte_5     (payload_byte_5),
		.payload_byte_6     (payload_byte_6),
		.payload_byte_7     (payload_byte_7),
		.segment_tag        (segment_tag),
		.out_valid          (out_valid),
		.out_stall          (out_stall),
		.frame_counted      (frame_counted),
		.frames_counted     (frames_counted),
		.sum_matches        (sum_matches),
		.complement_matches (complement_matches),
		.xor_matches        (xor_matches),
		.even_parity_frames (even_parity_frames),
		.changed_pairs      (changed_pairs),
		.check_changes      (check_changes),
		.changed_bits_total (changed_bits_total),
		.cfg_valid          (cfg_valid),
		.cfg_ready          (cfg_ready),
		.check_byte_index   (check_byte_index),
		.failures           (failures),
		.outstanding        (outstanding)
	);

	always #10 clk = ~clk;

	// receiver stalls in modes that are drawn anew at random whenever the mode counter runs out
	always @(posedge clk) begin
		if (stall_left == 0) begin
			stall_mode <= stall_mode_t'($urandom_range(0, 3));
			stall_left <= $urandom_range(20, 300);
		end else begin
			stall_left <= stall_left - 1;
		end
		case (stall_mode)
			FLOW:    out_stall <= 1'b0;
			LIGHT:   out_stall <= ($urandom_range(0, 3) == 0);
			HEAVY:   out_stall <= ($urandom_range(0, 3) != 0);
			default: out_stall <= ((stall_left % 8) < 6);
		endcase
	end

	task automatic send_frame(input logic sos, input logic [3:0] dlc, input payload_t data,
			input logic [15:0] seg);
		int unsigned gap;
		in_valid <= 1'b1;
		start_of_set <= sos;
		data_length <= dlc;
		payload_byte_0 <= data[0];
		payload_byte_1 <= data[1];
		payload_byte_2 <= data[2];
		payload_byte_3 <= data[3];
		payload_byte_4 <= data[4];
		payload_byte_5 <= data[5];
		payload_byte_6 <= data[6];
		payload_byte_7 <= data[7];
		segment_tag <= seg;
		do @(posedge clk); while (in_stall);
		frames_sent++;
		if (beats_left > 0)
			beats_left--;
		if (beats_left == 0) begin
			gap = gaps_on ? $urandom_range(0, 6) : 0;
			if (gap != 0) begin
				in_valid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			beats_left = $urandom_range(1, 24);
		end
	endtask

	// hold the sender until every result beat is back
	task automatic settle();
		in_valid <= 1'b0;
		@(posedge clk);
		while (outstanding != 0)
			@(posedge clk);
	endtask

	task automatic set_index(input int unsigned idx);
		settle();
		cfg_valid <= 1'b1;
		check_byte_index <= IDX_W'(idx);
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		cur_cb = idx;
	endtask

	// a run of frames in one segment with one length, check byte built by some scheme
	task automatic send_run(input int unsigned frames);
		logic [15:0]   seg;
		int unsigned   roll;
		int unsigned   dlc;
		int unsigned   len;
		int unsigned   f;
		int unsigned   j;
		check_scheme_t scheme;
		payload_t      data;
		byte_t         sum;
		byte_t         x;
		roll = $urandom_range(0, 9);
		seg = (roll == 0) ? 16'h0000 : (roll == 1) ? 16'hFFFF : 16'($urandom);
		roll = $urandom_range(0, 9);
		if (roll < 7)
			dlc = $urandom_range((cur_cb < 2) ? 2 : cur_cb + 1, 8);
		else if (roll < 8)
			dlc = $urandom_range(9, 15);
		else
			dlc = $urandom_range(0, cur_cb);
		len = (dlc > LANES) ? LANES : dlc;
		scheme = check_scheme_t'($urandom_range(0, 5));
		data = {$urandom, $urandom};
		for (f = 0; f < frames; f++) begin
			if (f != 0)
				repeat ($urandom_range(0, 3)) data[$urandom_range(0, 7)] = 8'($urandom);
			sum = '0;
			x = '0;
			for (j = 0; j < len; j++) begin
				if (j != cur_cb) begin
					sum = sum + data[j];
					x = x ^ data[j];
				end
			end
			case (scheme)
				SCH_SUM:    data[cur_cb] = sum;
				SCH_CPL:    data[cur_cb] = 8'd0 - sum;
				SCH_XOR:    data[cur_cb] = x;
				SCH_PARITY: begin
					data[cur_cb] = 8'($urandom);
					if ((($countones(x) + $countones(data[cur_cb])) % 2) != 0)
						data[cur_cb][0] = ~data[cur_cb][0];
				end
				SCH_RANDOM: data[cur_cb] = 8'($urandom);
				default:    ;
			endcase
			send_frame($urandom_range(0, 40) == 0, 4'(dlc), data, seg);
		end
	endtask

	initial begin
		#(RUN_LIMIT_NS);
		$display("[can_checksum_byte_evidence] ERROR");
		$finish;
	end

	initial begin
		int p;
		int n;
		arst_n <= 1'b0;
		in_valid <= 1'b0;
		start_of_set <= 1'b0;
		data_length <= '0;
		payload_byte_0 <= '0;
		payload_byte_1 <= '0;
		payload_byte_2 <= '0;
		payload_byte_3 <= '0;
		payload_byte_4 <= '0;
		payload_byte_5 <= '0;
		payload_byte_6 <= '0;
		payload_byte_7 <= '0;
		segment_tag <= '0;
		cfg_valid <= 1'b0;
		check_byte_index <= '0;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// byte index 7 from reset
		send_frame(1'b1, 4'd8, 64'h0000_0000_0000_0000, 16'h0000);
		send_frame(1'b0, 4'd8, 64'hFF00_0000_0000_00FF, 16'h0000);
		send_frame(1'b0, 4'd8, 64'hFF00_0000_0000_0001, 16'h0000);
		send_frame(1'b0, 4'd8, 64'hFF00_0000_0000_0001, 16'h0000);
		send_frame(1'b0, 4'd8, 64'hFFFF_FFFF_FFFF_FFFF, 16'hFFFF);
		send_frame(1'b0, 4'd15, 64'h0012_3456_789A_BCDE, 16'hFFFF);
		send_frame(1'b0, 4'd9, {$urandom, $urandom}, 16'hFFFF);
		send_frame(1'b0, 4'd7, {$urandom, $urandom}, 16'hFFFF);
		send_frame(1'b0, 4'd8, {$urandom, $urandom}, 16'hFFFF);
		send_frame(1'b0, 4'd0, {$urandom, $urandom}, 16'h0000);
		send_frame(1'b0, 4'd1, {$urandom, $urandom}, 16'h0000);
		send_frame(1'b1, 4'd8, 64'h5555_5555_5555_5555, 16'h1234);
		send_frame(1'b0, 4'd8, 64'hAAAA_AAAA_AAAA_AAAA, 16'h1234);

		set_index(0);
		send_frame(1'b0, 4'd2, 64'h0000_0000_0000_0707, 16'h0042);
		send_frame(1'b0, 4'd1, 64'h0000_0000_0000_0000, 16'h0042);
		send_frame(1'b0, 4'd2, 64'h0000_0000_0000_07F9, 16'h0042);
		send_frame(1'b0, 4'd2, 64'h0000_0000_0000_0808, 16'h0042);
		send_frame(1'b0, 4'd8, {$urandom, $urandom}, 16'h0042);

		set_index(3);
		send_frame(1'b0, 4'd3, {$urandom, $urandom}, 16'h0777);
		send_frame(1'b0, 4'd4, 64'h0000_0000_AA11_2233, 16'h0777);
		send_frame(1'b0, 4'd4, 64'h0000_0000_AA44_5566, 16'h0777);
		send_frame(1'b0, 4'd12, {$urandom, $urandom}, 16'h0777);

		for (p = 0; p < PHASES; p++) begin
			set_index((p == 0) ? 0 : (p == 1) ? 7 : $urandom_range(0, 7));
			n = frames_sent + RANDOM_FRAMES / PHASES;
			while (frames_sent < n) begin
				if ($urandom_range(0, 9) < 8)
					send_run($urandom_range(2, 12));
				else
					send_frame($urandom_range(0, 31) == 0, 4'($urandom_range(0, 15)),
						{$urandom, $urandom}, 16'($urandom));
				if ($urandom_range(0, 99) == 0)
					settle();
			end
		end

		// back-to-back stretch of changing pairs in one segment
		set_index(7);
		gaps_on = 1'b0;
		for (n = 0; n < B2B_FRAMES; n++) begin
			case (n % 4)
				1:       send_frame(1'b0, 4'd8, 64'hFF00_0000_0000_00FF, 16'h5A5A);
				3:       send_frame(1'b0, 4'd8, 64'hFF00_0000_0000_0001, 16'h5A5A);
				default: send_frame(n == 0, 4'd8, 64'h0000_0000_0000_0000, 16'h5A5A);
			endcase
		end
		gaps_on = 1'b1;
		send_run(6);

		settle();
		repeat (8) @(posedge clk);
		if (failures == 0 && outstanding == 0)
			$display("[can_checksum_byte_evidence] OK");
		else
			$display("[can_checksum_byte_evidence] ERROR");
		$finish;
	end

endmodule
